### hdl/day_count_to_calendar_datetime_unit_macros.svh
// Assertion macros for the day count to calendar date and time unit.
// Needs clk and arst_n in the scope that uses them.
`ifndef DAY_COUNT_TO_CALENDAR_DATETIME_UNIT_MACROS_SVH
`define DAY_COUNT_TO_CALENDAR_DATETIME_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DCDT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define DCDT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/dcdt_pkg.sv
// Shared types, constants and microcode for the day count to date and time unit.
// No dependencies.
`timescale 1ns / 1ps

package dcdt_pkg;

	localparam int DAY_NUMBER_BITS = 22;
	localparam int YEAR_BITS       = DAY_NUMBER_BITS - 7;
	localparam int MS_BITS         = 27;
	localparam int ARG_BITS        = 5;
	localparam int PC_BITS         = 4;

	localparam logic [31:0] JULIAN_OFFSET = 32'd2305447;
	localparam logic [31:0] PLAIN_OFFSET  = 32'd584022;
	localparam logic [31:0] YEAR_LIMIT    = 32'd16383;
	localparam int BASE_YEAR     = 1600;
	localparam int DAYS_400      = 146097;
	localparam int MS_PER_HOUR   = 3600000;
	localparam int MS_PER_MINUTE = 60000;
	localparam int MS_PER_SECOND = 1000;
	localparam int MS_PER_DAY    = 86400000;

	typedef logic [DAY_NUMBER_BITS-1:0] dnum_t;
	typedef logic [YEAR_BITS-1:0]       year_t;
	typedef logic [MS_BITS-1:0]         tms_t;
	typedef logic [ARG_BITS-1:0]        arg_t;
	typedef logic [PC_BITS-1:0]         pc_t;

	typedef struct packed {
		dnum_t      day_number;
		logic       julian_mode;
		tms_t       millis_of_day;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        out_of_range;
	} out_item_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_Q400,
		OP_C100,
		OP_B4,
		OP_Y1,
		OP_MON,
		OP_HOUR,
		OP_MIN,
		OP_SEC,
		OP_DONE
	} op_t;

	typedef struct packed {
		op_t  op;
		arg_t arg;
	} mc_word_t;

	typedef struct packed {
		op_t  op;
		arg_t k;
		arg_t cnt;
		logic take;
		logic adv;
		logic load;
	} ctrl_t;

	// Shift count of the first 400-year subtraction: the quotient stays below
	// 2**(DAY_NUMBER_BITS-17) since one cycle is longer than 2**17 days.
	localparam arg_t Q400_K0 = arg_t'(DAY_NUMBER_BITS - 18);

	function automatic mc_word_t mc_word(input pc_t pc);
		mc_word_t w;
		case (pc)
			4'd0:    w = '{op: OP_Q400, arg: Q400_K0};
			4'd1:    w = '{op: OP_C100, arg: arg_t'(3)};
			4'd2:    w = '{op: OP_B4,   arg: arg_t'(24)};
			4'd3:    w = '{op: OP_Y1,   arg: arg_t'(3)};
			4'd4:    w = '{op: OP_MON,  arg: arg_t'(11)};
			4'd5:    w = '{op: OP_HOUR, arg: arg_t'(4)};
			4'd6:    w = '{op: OP_MIN,  arg: arg_t'(5)};
			4'd7:    w = '{op: OP_SEC,  arg: arg_t'(5)};
			default: w = '{op: OP_DONE, arg: '0};
		endcase
		return w;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] len;
		case (m)
			4'd1:    len = 5'd28;
			4'd3:    len = 5'd30;
			4'd5:    len = 5'd30;
			4'd8:    len = 5'd30;
			4'd10:   len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

### hdl/dcdt_seq.sv
// Microcode sequencer: step counter, control ROM from dcdt_pkg, loop counters.
// Depends on dcdt_pkg.
`timescale 1ns / 1ps

module dcdt_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           fits,
	output logic           busy,
	output dcdt_pkg::ctrl_t ctrl
);

	logic               busy_q;
	dcdt_pkg::pc_t      pc_q;
	dcdt_pkg::arg_t     k_q;
	dcdt_pkg::arg_t     cnt_q;
	dcdt_pkg::mc_word_t word;
	dcdt_pkg::mc_word_t nword;
	dcdt_pkg::mc_word_t fword;
	logic               is_div;
	logic               take;
	logic               adv;
	logic               load;

	assign word  = dcdt_pkg::mc_word(pc_q);
	assign nword = dcdt_pkg::mc_word(pc_q + 1'b1);
	assign fword = dcdt_pkg::mc_word('0);
	assign load  = start && !busy_q;
	assign busy  = busy_q;

	always_comb begin
		is_div = word.op inside {dcdt_pkg::OP_Q400, dcdt_pkg::OP_HOUR,
			dcdt_pkg::OP_MIN, dcdt_pkg::OP_SEC};
		take = 1'b0;
		adv  = 1'b0;
		if (busy_q) begin
			if (is_div) begin
				take = 1'b1;
				adv  = (k_q == '0);
			end else if (word.op == dcdt_pkg::OP_DONE) begin
				adv = 1'b1;
			end else begin
				take = fits && (cnt_q < word.arg);
				adv  = !take;
			end
		end
		ctrl.op   = busy_q ? word.op : dcdt_pkg::OP_NOP;
		ctrl.k    = k_q;
		ctrl.cnt  = cnt_q;
		ctrl.take = take;
		ctrl.adv  = adv;
		ctrl.load = load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
			k_q    <= '0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			pc_q   <= '0;
			k_q    <= fword.arg;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (adv) begin
				pc_q  <= pc_q + 1'b1;
				k_q   <= nword.arg;
				cnt_q <= '0;
				if (word.op == dcdt_pkg::OP_DONE) begin
					busy_q <= 1'b0;
				end
			end else if (is_div) begin
				k_q <= k_q - 1'b1;
			end else if (take) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

### hdl/day_count_to_calendar_datetime_unit.sv
// Top level: datapath of the day count to calendar date and time unit.
// Depends on dcdt_pkg, dcdt_seq and the assertion macro header.
`timescale 1ns / 1ps
`include "day_count_to_calendar_datetime_unit_macros.svh"

// An item is taken when start is high while busy is low; busy then stays high
// until the result is out. The result is marked by done for one cycle and must
// be captured then, though result keeps it until the next one is written. The
// microcode program runs each item on two compare-and-subtract datapaths, one
// for the day count and one for the time of day: a bit-serial 400-year divide,
// up to 3 century, 24 four-year and 3 single-year strides, up to 11 month steps,
// and bit-serial divides for hour, minute and second. A new item may start in the
// cycle done is high. Dates before 1.1.1600 or after the year 16383 read
// 1.1.1600 and a time of a full day or more reads 23:59:59; both set
// out_of_range.
module day_count_to_calendar_datetime_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  dcdt_pkg::in_item_t   request,
	output logic                 busy,
	output logic                 done,
	output dcdt_pkg::out_item_t  result
);

	dcdt_pkg::ctrl_t     ctrl;
	logic                fits;
	logic                date_fit;
	logic                tfit;
	dcdt_pkg::dnum_t     sub_amt;
	dcdt_pkg::year_t     y_inc;
	dcdt_pkg::tms_t      tdiv;
	logic [5:0]          qnext;
	logic [31:0]         offset;
	logic                year_over;
	logic                date_def;

	dcdt_pkg::dnum_t     r_q;
	dcdt_pkg::year_t     y_q;
	dcdt_pkg::tms_t      tm_q;
	logic [5:0]          qacc_q;
	logic                cent0_q;
	logic                bleap_q;
	logic                leap_q;
	logic [3:0]          mon_q;
	logic [4:0]          hour_q;
	logic [5:0]          min_q;
	logic [5:0]          sec_q;
	logic                date_bad_q;
	logic                ms_bad_q;
	logic                done_q;
	dcdt_pkg::out_item_t result_q;

	dcdt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.fits   (fits),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	assign offset = request.julian_mode ? dcdt_pkg::JULIAN_OFFSET : dcdt_pkg::PLAIN_OFFSET;

	always_comb begin
		sub_amt = '0;
		y_inc   = '0;
		tdiv    = '0;
		case (ctrl.op)
			dcdt_pkg::OP_Q400: begin
				sub_amt = dcdt_pkg::dnum_t'(dcdt_pkg::DAYS_400) << ctrl.k;
				y_inc   = dcdt_pkg::year_t'(400) << ctrl.k;
			end
			dcdt_pkg::OP_C100: begin
				sub_amt = (ctrl.cnt == '0) ? dcdt_pkg::dnum_t'(36525) : dcdt_pkg::dnum_t'(36524);
				y_inc   = dcdt_pkg::year_t'(100);
			end
			dcdt_pkg::OP_B4: begin
				sub_amt = (ctrl.cnt == '0 && !cent0_q) ?
					dcdt_pkg::dnum_t'(1460) : dcdt_pkg::dnum_t'(1461);
				y_inc   = dcdt_pkg::year_t'(4);
			end
			dcdt_pkg::OP_Y1: begin
				sub_amt = (ctrl.cnt == '0 && bleap_q) ?
					dcdt_pkg::dnum_t'(366) : dcdt_pkg::dnum_t'(365);
				y_inc   = dcdt_pkg::year_t'(1);
			end
			dcdt_pkg::OP_MON: begin
				sub_amt = dcdt_pkg::dnum_t'(dcdt_pkg::month_len(ctrl.cnt[3:0]))
					+ dcdt_pkg::dnum_t'(ctrl.cnt == 5'd1 && leap_q);
			end
			dcdt_pkg::OP_HOUR: tdiv = dcdt_pkg::tms_t'(dcdt_pkg::MS_PER_HOUR) << ctrl.k;
			dcdt_pkg::OP_MIN:  tdiv = dcdt_pkg::tms_t'(dcdt_pkg::MS_PER_MINUTE) << ctrl.k;
			dcdt_pkg::OP_SEC:  tdiv = dcdt_pkg::tms_t'(dcdt_pkg::MS_PER_SECOND) << ctrl.k;
			default: begin
				sub_amt = '0;
			end
		endcase
		date_fit  = (r_q >= sub_amt);
		tfit      = (tm_q >= tdiv);
		fits      = (ctrl.op inside {dcdt_pkg::OP_HOUR, dcdt_pkg::OP_MIN,
			dcdt_pkg::OP_SEC}) ? tfit : date_fit;
		qnext     = {qacc_q[4:0], tfit};
		year_over = (32'(y_q) > dcdt_pkg::YEAR_LIMIT);
		date_def  = date_bad_q || year_over;
	end

	// Datapath registers: payload only, no reset.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			r_q        <= dcdt_pkg::dnum_t'(32'(request.day_number) - offset - 32'd1);
			y_q        <= dcdt_pkg::year_t'(dcdt_pkg::BASE_YEAR);
			tm_q       <= request.millis_of_day;
			qacc_q     <= '0;
			date_bad_q <= (32'(request.day_number) <= offset);
			ms_bad_q   <= (request.millis_of_day >= dcdt_pkg::tms_t'(dcdt_pkg::MS_PER_DAY));
		end else begin
			case (ctrl.op)
				dcdt_pkg::OP_Q400, dcdt_pkg::OP_C100, dcdt_pkg::OP_B4,
				dcdt_pkg::OP_Y1, dcdt_pkg::OP_MON: begin
					if (ctrl.take && date_fit) begin
						r_q <= r_q - sub_amt;
						y_q <= y_q + y_inc;
					end
					if (ctrl.adv) begin
						case (ctrl.op)
							dcdt_pkg::OP_C100: cent0_q <= (ctrl.cnt == '0);
							dcdt_pkg::OP_B4:   bleap_q <= !(ctrl.cnt == '0 && !cent0_q);
							dcdt_pkg::OP_Y1:   leap_q  <= (ctrl.cnt == '0) && bleap_q;
							dcdt_pkg::OP_MON:  mon_q   <= ctrl.cnt[3:0];
							default:           mon_q   <= mon_q;
						endcase
					end
				end
				dcdt_pkg::OP_HOUR, dcdt_pkg::OP_MIN, dcdt_pkg::OP_SEC: begin
					if (tfit) begin
						tm_q <= tm_q - tdiv;
					end
					if (ctrl.adv) begin
						qacc_q <= '0;
						case (ctrl.op)
							dcdt_pkg::OP_HOUR: hour_q <= qnext[4:0];
							dcdt_pkg::OP_MIN:  min_q  <= qnext;
							default:           sec_q  <= qnext;
						endcase
					end else begin
						qacc_q <= qnext;
					end
				end
				dcdt_pkg::OP_DONE: begin
					result_q.day          <= date_def ? 5'd1 : 5'(r_q) + 5'd1;
					result_q.month        <= date_def ? 4'd1 : mon_q + 4'd1;
					result_q.year         <= date_def ? 14'(dcdt_pkg::BASE_YEAR) : 14'(y_q);
					result_q.hour         <= ms_bad_q ? 5'd23 : hour_q;
					result_q.minute       <= ms_bad_q ? 6'd59 : min_q;
					result_q.second       <= ms_bad_q ? 6'd59 : sec_q;
					result_q.out_of_range <= date_def || ms_bad_q;
				end
				default: begin
					r_q <= r_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (ctrl.op == dcdt_pkg::OP_DONE);
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`DCDT_ASSERT_SAME(a_done_not_busy, done, !busy, "result strobed while still busy")
	`DCDT_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accepted item not held busy")
	`DCDT_ASSERT_SAME(a_month_range, done, result.month != 4'd0 && result.month <= 4'd12, "month out of range")
	`DCDT_ASSERT_SAME(a_hour_range, done, result.hour <= 5'd23, "hour out of range")

endmodule

### tb/datetime_checker.sv
// Scoreboard for the day count to calendar date and time unit: predicts each
// accepted item and compares every strobed result. Depends on dcdt_pkg.
`timescale 1ns / 1ps

module datetime_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  dcdt_pkg::in_item_t   request,
	input  logic                 done,
	input  dcdt_pkg::out_item_t  result,
	output int                   mismatches,
	output int                   awaiting
);
	import dcdt_pkg::*;

	localparam longint unsigned JD_EPOCH    = 2305447;
	localparam longint unsigned CE_EPOCH    = 584022;
	localparam longint unsigned FIRST_YEAR  = 1600;
	localparam longint unsigned CYCLE_DAYS  = 146097;
	localparam longint unsigned YEAR_CEIL   = 16383;
	localparam longint unsigned HOUR_MS     = 3600000;
	localparam longint unsigned MINUTE_MS   = 60000;
	localparam longint unsigned SECOND_MS   = 1000;
	localparam longint unsigned DAY_MS      = 86400000;

	localparam int unsigned DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	out_item_t expected_datetimes [$];

	initial begin
		mismatches = 0;
		awaiting   = 0;
	end

	function automatic logic leap_year(input longint unsigned yr);
		return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
	endfunction

	function automatic out_item_t calendar_of(input in_item_t req);
		out_item_t       o;
		longint unsigned epoch;
		longint unsigned rem;
		longint unsigned yr;
		longint unsigned ms;
		int unsigned     mon;
		logic            leap;
		o = '{day: 5'd1, month: 4'd1, year: 14'd1600, default: '0};
		epoch = req.julian_mode ? JD_EPOCH : CE_EPOCH;
		if (longint'(req.day_number) <= epoch) begin
			o.out_of_range = 1'b1;
		end else begin
			rem = longint'(req.day_number) - epoch - 1;
			yr = FIRST_YEAR + 400 * (rem / CYCLE_DAYS);
			rem = rem % CYCLE_DAYS;
			leap = leap_year(yr);
			while (rem >= (leap ? 366 : 365)) begin
				rem = rem - (leap ? 366 : 365);
				yr = yr + 1;
				leap = leap_year(yr);
			end
			mon = 0;
			while (mon < 11 && rem >= DAYS_IN_MONTH[mon] + ((mon == 1 && leap) ? 1 : 0)) begin
				rem = rem - (DAYS_IN_MONTH[mon] + ((mon == 1 && leap) ? 1 : 0));
				mon = mon + 1;
			end
			if (yr > YEAR_CEIL) begin
				o.out_of_range = 1'b1;
			end else begin
				o.year  = 14'(yr);
				o.month = 4'(mon + 1);
				o.day   = 5'(rem + 1);
			end
		end
		ms = longint'(req.millis_of_day);
		if (ms >= DAY_MS) begin
			o.out_of_range = 1'b1;
			o.hour   = 5'd23;
			o.minute = 6'd59;
			o.second = 6'd59;
		end else begin
			o.hour   = 5'(ms / HOUR_MS);
			o.minute = 6'((ms / MINUTE_MS) % 60);
			o.second = 6'((ms / SECOND_MS) % 60);
		end
		return o;
	endfunction

	task automatic report_field(input string field, input int unsigned want,
			input int unsigned got);
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		mismatches++;
	endtask

	// Retire the result of this edge before taking the item of the same edge.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_datetimes.size() == 0) begin
					$display("%0t: result with no item waiting, expected none, got %p",
						$time, result);
					mismatches++;
				end else begin
					want = expected_datetimes.pop_front();
					if (result.day !== want.day)
						report_field("day", want.day, result.day);
					if (result.month !== want.month)
						report_field("month", want.month, result.month);
					if (result.year !== want.year)
						report_field("year", want.year, result.year);
					if (result.hour !== want.hour)
						report_field("hour", want.hour, result.hour);
					if (result.minute !== want.minute)
						report_field("minute", want.minute, result.minute);
					if (result.second !== want.second)
						report_field("second", want.second, result.second);
					if (result.out_of_range !== want.out_of_range)
						report_field("out_of_range", want.out_of_range, result.out_of_range);
				end
			end
			if (start && !busy)
				expected_datetimes.push_back(calendar_of(request));
			awaiting <= expected_datetimes.size();
		end
	end

endmodule

### tb/testbench.sv
// Top of the day count to calendar date and time regression: drives directed and
// random items into the unit and gives the verdict. Depends on dcdt_pkg,
// datetime_checker and day_count_to_calendar_datetime_unit.
`timescale 1ns / 1ps

module testbench;
	import dcdt_pkg::*;

	localparam int RANDOM_ITEMS = 400;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 80;
	localparam int JD_FIRST     = 2305448;
	localparam int CE_FIRST     = 584023;
	localparam int DN_MAX       = (1 << DAY_NUMBER_BITS) - 1;
	localparam int TMS_MAX      = (1 << MS_BITS) - 1;

	logic      clk;
	logic      arst_n;
	logic      start;
	in_item_t  request;
	logic      busy;
	logic      done;
	out_item_t result;
	int        mismatches;
	int        awaiting;
	int        cycles;

	day_count_to_calendar_datetime_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.request(request),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	datetime_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.mismatches(mismatches),
		.awaiting  (awaiting)
	);

	initial clk = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial cycles = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic in_item_t item_of(input int dn, input logic jm, input int ms);
		return '{day_number: dnum_t'(dn), julian_mode: jm, millis_of_day: tms_t'(ms)};
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int       pick;
		int       first;
		it.julian_mode = 1'($urandom_range(1));
		first = it.julian_mode ? JD_FIRST : CE_FIRST;
		pick = $urandom_range(99);
		if (pick < 15)
			it.day_number = dnum_t'($urandom);
		else if (pick < 25)
			it.day_number = dnum_t'(first - 400 + $urandom_range(800));
		else
			it.day_number = dnum_t'($urandom_range(DN_MAX, first));
		pick = $urandom_range(99);
		if (pick < 10)
			it.millis_of_day = tms_t'($urandom_range(TMS_MAX, MS_PER_DAY));
		else if (pick < 15)
			it.millis_of_day = tms_t'($urandom);
		else
			it.millis_of_day = tms_t'($urandom_range(MS_PER_DAY - 1, 0));
		return it;
	endfunction

	// Hold start until the unit takes the item.
	task automatic issue(input in_item_t it);
		start   <= 1'b1;
		request <= it;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic maybe_idle(input bit quiet);
		int gap;
		if (!quiet && $urandom_range(99) < 19) begin
			gap = $urandom_range(70, 1);
			repeat (gap) begin
				start   <= 1'b0;
				request <= in_item_t'({$urandom, $urandom});
				@(posedge clk);
			end
		end
	endtask

	initial begin
		in_item_t directed [$];
		arst_n  = 1'b0;
		start   = 1'b0;
		request = '0;

		directed.push_back(item_of(0, 1'b1, 0));
		directed.push_back(item_of(0, 1'b0, 0));
		directed.push_back(item_of(JD_FIRST - 1, 1'b1, 0));
		directed.push_back(item_of(JD_FIRST, 1'b1, 0));
		directed.push_back(item_of(CE_FIRST - 1, 1'b0, 1));
		directed.push_back(item_of(CE_FIRST, 1'b0, MS_PER_DAY - 1));
		directed.push_back(item_of(DN_MAX, 1'b1, MS_PER_DAY - 1));
		directed.push_back(item_of(DN_MAX, 1'b0, TMS_MAX));
		directed.push_back(item_of(0, 1'b0, MS_PER_DAY));
		directed.push_back(item_of(CE_FIRST + 59, 1'b0, 999));
		directed.push_back(item_of(CE_FIRST + 365, 1'b0, 1000));
		directed.push_back(item_of(CE_FIRST + 36525 + 58, 1'b0, 59999));
		directed.push_back(item_of(CE_FIRST + 36525 + 59, 1'b0, 60000));
		directed.push_back(item_of(CE_FIRST + DAYS_400 - 1, 1'b0, 3599999));
		directed.push_back(item_of(CE_FIRST + DAYS_400, 1'b0, 3600000));
		directed.push_back(item_of(JD_FIRST + DAYS_400 + 59, 1'b1, 43200000));
		directed.push_back(item_of(JD_FIRST + DAYS_400 + 60, 1'b1, 86399000));
		directed.push_back(item_of(2451545, 1'b1, 12345678));
		directed.push_back(item_of(JD_FIRST + 30, 1'b1, 1));
		directed.push_back(item_of(JD_FIRST + 31, 1'b1, 2));
		directed.push_back(item_of(DN_MAX, 1'b0, 0));
		directed.push_back(item_of(1 << (DAY_NUMBER_BITS - 1), 1'b1, 1 << (MS_BITS - 1)));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			maybe_idle(1'b0);
			issue(directed[i]);
		end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			maybe_idle(n >= 150 && n < 250);
			issue(random_item());
		end
		start <= 1'b0;

		while (awaiting != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && awaiting == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/dcdt_pkg.sv
hdl/dcdt_seq.sv
hdl/day_count_to_calendar_datetime_unit.sv
tb/datetime_checker.sv
tb/testbench.sv
